>>> design/etec_pkg.sv
package etec_pkg;

  localparam int NumSources = 3;
  localparam int SrcAw = (NumSources > 1) ? $clog2(NumSources) : 1;

  localparam int SrcW = 2;
  localparam int DataW = 16;
  localparam int StampW = 32;
  localparam int CapW = 6;
  localparam int BudgetW = 16;
  localparam int TotalW = 18;
  localparam int CountW = 32;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  localparam int InTdataW = 48;
  localparam int OutTdataW = 176;

  localparam logic [SrcW-1:0] SrcKeyboard = 2'd1;
  localparam logic [SrcW-1:0] SrcDisk = 2'd2;

  localparam logic [TotalW-1:0] TotalMax = 18'h3FFFF;

  localparam logic [CfgIdxW-1:0] CfgKeyboardCap = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgDiskCap = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgTimerCap = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgKeyboardBudget = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDiskBudget = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgTimerBudget = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgQualityThreshold = 3'd6;

  typedef struct packed {
    logic [CapW-1:0]    keyboard_cap;
    logic [CapW-1:0]    disk_cap;
    logic [CapW-1:0]    timer_cap;
    logic [BudgetW-1:0] keyboard_budget;
    logic [BudgetW-1:0] disk_budget;
    logic [BudgetW-1:0] timer_budget;
    logic [BudgetW-1:0] quality_threshold;
  } cfg_t;

  // per-source entry kept in the source ram
  typedef struct packed {
    logic [CountW-1:0]  events;
    logic [BudgetW-1:0] spent;
  } src_entry_t;

  localparam int EntryW = $bits(src_entry_t);

  // number of bits needed to hold v, 0 for v == 0
  function automatic logic [CapW-1:0] bit_len(logic [StampW-1:0] v);
    logic [CapW-1:0] n;
    n = '0;
    for (int i = 0; i < StampW; i++) begin
      if (v[i]) n = CapW'(i + 1);
    end
    return n;
  endfunction

endpackage

>>> design/etec_ram.sv
module etec_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                              wdata_i,
  input  logic                                          re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                              rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/etec_cfg_regs.sv
module etec_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [etec_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [etec_pkg::CfgDataW-1:0] cfg_data_i,
  output etec_pkg::cfg_t                cfg_o
);
  import etec_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgKeyboardCap:      cfg_d.keyboard_cap = cfg_data_i[CapW-1:0];
        CfgDiskCap:          cfg_d.disk_cap = cfg_data_i[CapW-1:0];
        CfgTimerCap:         cfg_d.timer_cap = cfg_data_i[CapW-1:0];
        CfgKeyboardBudget:   cfg_d.keyboard_budget = cfg_data_i[BudgetW-1:0];
        CfgDiskBudget:       cfg_d.disk_budget = cfg_data_i[BudgetW-1:0];
        CfgTimerBudget:      cfg_d.timer_budget = cfg_data_i[BudgetW-1:0];
        CfgQualityThreshold: cfg_d.quality_threshold = cfg_data_i[BudgetW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.keyboard_cap      <= CapW'(4);
      cfg_q.disk_cap          <= CapW'(2);
      cfg_q.timer_cap         <= '0;
      cfg_q.keyboard_budget   <= BudgetW'(4096);
      cfg_q.disk_budget       <= BudgetW'(64);
      cfg_q.timer_budget      <= '0;
      cfg_q.quality_threshold <= BudgetW'(256);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/event_timing_entropy_credit.sv
// Event timing entropy credit estimator. Each input item is one source event
// (source id in tuser, payload and timestamp in tdata); each produces exactly one
// result item carrying the mixed sample word, the credit granted after the
// per-source cap and lifetime budget, the running total, the quality flag, the
// source's own counters and the interval statistics. Source id values at or above
// the number of sources are flagged in the result tuser and change nothing. The
// block takes one item per clock cycle while the output is not stalled. The rate
// is set by the per-source read-modify-write: event count and spent credit live
// in a small ram read at accept and written when the item leaves stage 1, with
// the previous write bypassed when back-to-back items hit the same source.
// Per-entry valid bits make the ram read as zero after reset, so there is no
// clearing pass. Configuration writes take effect at the next clock edge and are
// meant to be done while no item is in flight.
module event_timing_entropy_credit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write port
  input  logic                           cfg_we_i,
  input  logic [etec_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [etec_pkg::CfgDataW-1:0]  cfg_data_i,
  // event stream in
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [15:0] event_data, [47:16] timestamp
  input  logic [etec_pkg::InTdataW-1:0]  s_axis_tdata,
  // [1:0] source_id
  input  logic [etec_pkg::SrcW-1:0]      s_axis_tuser,
  // result stream out
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [31:0] sample_word, [37:32] credit_granted, [55:38] total_credit,
  // [56] quality_ok, [88:57] source_events, [104:89] source_credit,
  // [110:105] distinct_low_bits, [142:111] min_interval,
  // [174:143] max_interval, [175] zero
  output logic [etec_pkg::OutTdataW-1:0] m_axis_tdata,
  // [0] ignored
  output logic                           m_axis_tuser
);
  import etec_pkg::*;

  cfg_t cfg;

  etec_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  // handshake and pipeline control
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic in_accept, s1_fire;

  assign s1_fire = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign in_accept = s_axis_tvalid && s_axis_tready;

  logic [SrcAw-1:0] in_addr;
  assign in_addr = SrcAw'(s_axis_tuser);

  // stage 1 item registers
  logic [SrcW-1:0]   s1_src_q;
  logic [DataW-1:0]  s1_data_q;
  logic [StampW-1:0] s1_stamp_q;
  logic              byp_hit_q, byp_hit_d;
  src_entry_t        byp_q;

  // source ram
  logic             wr_en;
  logic [SrcAw-1:0] s1_addr;
  src_entry_t       wr_entry, rd_entry;
  logic [EntryW-1:0] rd_raw;
  logic [NumSources-1:0] vld_q, vld_d;

  assign s1_addr = SrcAw'(s1_src_q);

  etec_ram #(
    .Width (EntryW),
    .Depth (NumSources)
  ) u_src_ram (
    .clk_i,
    .we_i    (wr_en),
    .waddr_i (s1_addr),
    .wdata_i (wr_entry),
    .re_i    (in_accept),
    .raddr_i (in_addr),
    .rdata_o (rd_raw)
  );

  // a write in the cycle of the read is not seen by the ram output
  assign byp_hit_d = wr_en && (s1_addr == in_addr);

  // global state
  logic [StampW-1:0] last_stamp_q, last_d1_q, last_d2_q;
  logic [TotalW-1:0] total_q, total_d;
  logic [31:0]       seen_q, seen_d;
  logic [CapW-1:0]   distinct_q, distinct_d;
  logic [StampW-1:0] min_q, min_d, max_q, max_d;
  logic              iv_seen_q;

  // stage 1 compute
  logic              s1_ign;
  logic [StampW-1:0] d1, d2, d3;
  logic [CapW-1:0]   credit, w1, w2, w3, cap;
  logic [BudgetW-1:0] budget, remaining;
  logic [TotalW:0]   total_sum;
  src_entry_t        cur;
  logic [OutTdataW-1:0] out_d;
  logic [OutTdataW-1:0] out_tdata_q;
  logic                 out_ign_q;

  assign s1_ign = 32'(s1_src_q) >= NumSources;
  assign wr_en = s1_fire && !s1_ign;

  always_comb begin
    rd_entry = rd_raw;
    if (byp_hit_q) begin
      cur = byp_q;
    end else if (vld_q[s1_addr]) begin
      cur = rd_entry;
    end else begin
      cur = '0;
    end

    d1 = s1_stamp_q - last_stamp_q;
    d2 = d1 - last_d1_q;
    d3 = d2 - last_d2_q;
    w1 = bit_len(d1);
    w2 = bit_len(d2);
    w3 = bit_len(d3);

    case (s1_src_q)
      SrcKeyboard: begin
        cap = cfg.keyboard_cap;
        budget = cfg.keyboard_budget;
      end
      SrcDisk: begin
        cap = cfg.disk_cap;
        budget = cfg.disk_budget;
      end
      default: begin
        cap = cfg.timer_cap;
        budget = cfg.timer_budget;
      end
    endcase

    credit = w1;
    if (w2 < credit) credit = w2;
    if (w3 < credit) credit = w3;
    if (credit > cap) credit = cap;
    remaining = (cur.spent >= budget) ? '0 : budget - cur.spent;
    if (BudgetW'(credit) > remaining) credit = remaining[CapW-1:0];

    wr_entry.events = cur.events + CountW'(1);
    wr_entry.spent = cur.spent + BudgetW'(credit);

    total_sum = {1'b0, total_q} + (TotalW + 1)'(credit);
    total_d = total_sum[TotalW] ? TotalMax : total_sum[TotalW-1:0];

    seen_d = seen_q | (32'(1) << d1[4:0]);
    distinct_d = distinct_q + CapW'(!seen_q[d1[4:0]]);
    min_d = (!iv_seen_q || d1 < min_q) ? d1 : min_q;
    max_d = (d1 > max_q) ? d1 : max_q;

    vld_d = vld_q;
    vld_d[s1_addr] = 1'b1;

    out_d = '0;
    if (s1_ign) begin
      out_d[55:38]   = total_q;
      out_d[56]      = total_q >= TotalW'(cfg.quality_threshold);
      out_d[110:105] = distinct_q;
      out_d[142:111] = iv_seen_q ? min_q : '0;
      out_d[174:143] = max_q;
    end else begin
      out_d[31:0]    = d1 ^ {s1_data_q, 16'h0000} ^ 32'(s1_src_q) ^ s1_stamp_q;
      out_d[37:32]   = credit;
      out_d[55:38]   = total_d;
      out_d[56]      = total_d >= TotalW'(cfg.quality_threshold);
      out_d[88:57]   = wr_entry.events;
      out_d[104:89]  = wr_entry.spent;
      out_d[110:105] = distinct_d;
      out_d[142:111] = min_d;
      out_d[174:143] = max_d;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      byp_hit_q    <= 1'b0;
      vld_q        <= '0;
      last_stamp_q <= '0;
      last_d1_q    <= '0;
      last_d2_q    <= '0;
      total_q      <= '0;
      seen_q       <= '0;
      distinct_q   <= '0;
      min_q        <= '1;
      max_q        <= '0;
      iv_seen_q    <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        byp_hit_q <= byp_hit_d;
      end
      if (wr_en) begin
        vld_q        <= vld_d;
        last_stamp_q <= s1_stamp_q;
        last_d1_q    <= d1;
        last_d2_q    <= d2;
        total_q      <= total_d;
        seen_q       <= seen_d;
        distinct_q   <= distinct_d;
        min_q        <= min_d;
        max_q        <= max_d;
        iv_seen_q    <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_src_q   <= s_axis_tuser;
      s1_data_q  <= s_axis_tdata[15:0];
      s1_stamp_q <= s_axis_tdata[47:16];
      byp_q      <= wr_entry;
    end
    if (s1_fire) begin
      out_tdata_q <= out_d;
      out_ign_q   <= s1_ign;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_tdata_q;
  assign m_axis_tuser  = out_ign_q;

  // distinct count tracks the seen mask
  a_distinct_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(distinct_q) == $countones(seen_q))
    else $error("distinct count out of step with seen mask");

  // running total only grows
  a_total_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> total_q >= $past(total_q))
    else $error("total credit decreased");

  // min never above max once an interval was taken
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iv_seen_q |-> min_q <= max_q)
    else $error("min interval above max interval");

  // an ignored result grants nothing
  a_ignored_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[37:32] == '0 &&
    m_axis_tdata[88:57] == '0))
    else $error("ignored item carries credit or count");

  // granted credit never exceeds the widest difference
  a_credit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[37:32] <= 6'd32)
    else $error("credit above 32 bits");

endmodule

>>> tb/sv/event_timing_entropy_credit_tb.sv
module event_timing_entropy_credit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import etec_pkg::*;

  localparam int HoldOffCycles = 300;
  localparam int WatchdogLimit = 3000;
  localparam int SettleCycles = 4;
  localparam int TailCycles = 8;
  localparam int MaxReports = 40;

  localparam logic [SrcW-1:0] SrcTimer = 2'd0;
  localparam logic [SrcW-1:0] SrcInvalid = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;

  typedef struct packed {
    logic               ignored;
    logic [StampW-1:0]  mixed_word;
    logic [CapW-1:0]    credit;
    logic [TotalW-1:0]  total;
    logic               quality;
    logic [CountW-1:0]  events;
    logic [BudgetW-1:0] spent;
    logic [5:0]         distinct;
    logic [StampW-1:0]  min_gap;
    logic [StampW-1:0]  max_gap;
  } credit_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;
  logic [SrcW-1:0]      s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  // predictor copy of the block's configuration
  logic [CapW-1:0]    keyboard_cap, disk_cap, timer_cap;
  logic [BudgetW-1:0] keyboard_limit, disk_limit, timer_limit;
  logic [BudgetW-1:0] quality_min;

  // predictor copy of the block's state
  logic [StampW-1:0]  prev_stamp, prev_gap, prev_gap_delta;
  logic [CountW-1:0]  src_event_count [NumSources];
  logic [BudgetW-1:0] src_spent [NumSources];
  logic [TotalW-1:0]  credit_sum;
  logic [31:0]        low_bit_mask;
  logic [StampW-1:0]  min_gap, max_gap;
  logic               gap_seen;

  credit_result_t pending_credits [$];
  int error_count;
  int hold_off_reqs;
  int hold_off_served;
  int burst_left;

  // stimulus side view of the timing so that intervals can be shaped
  logic [StampW-1:0] offered_stamp, offered_gap;

  event_timing_entropy_credit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [CapW-1:0] bitwidth_of(logic [StampW-1:0] v);
    logic [CapW-1:0] n;
    n = '0;
    for (int i = StampW - 1; i >= 0; i--) begin
      if (v[i] && n == '0) n = CapW'(i + 1);
    end
    return n;
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MaxReports) $display("[%0t] ERROR: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // works out the result of one accepted event and queues it
  task automatic estimate_credit(input logic [SrcW-1:0] src, input logic [DataW-1:0] data,
                                 input logic [StampW-1:0] stamp);
    credit_result_t r;
    logic [StampW-1:0] gap, gap_delta, gap_curve;
    logic [CapW-1:0] credit, cap, w;
    logic [BudgetW-1:0] limit, left;
    logic [TotalW:0] sum;
    r = '0;
    if (int'(src) >= NumSources) begin
      r.ignored = 1'b1;
    end else begin
      gap = stamp - prev_stamp;
      gap_delta = gap - prev_gap;
      gap_curve = gap_delta - prev_gap_delta;
      prev_stamp = stamp;
      prev_gap = gap;
      prev_gap_delta = gap_delta;

      r.mixed_word = gap ^ {data, 16'h0000} ^ StampW'(src) ^ stamp;
      src_event_count[src] = src_event_count[src] + 1'b1;
      low_bit_mask[gap[4:0]] = 1'b1;
      if (!gap_seen || gap < min_gap) min_gap = gap;
      if (gap > max_gap) max_gap = gap;
      gap_seen = 1'b1;

      if (src == SrcKeyboard) begin
        cap = keyboard_cap;
        limit = keyboard_limit;
      end else if (src == SrcDisk) begin
        cap = disk_cap;
        limit = disk_limit;
      end else begin
        cap = timer_cap;
        limit = timer_limit;
      end

      credit = bitwidth_of(gap);
      w = bitwidth_of(gap_delta);
      if (w < credit) credit = w;
      w = bitwidth_of(gap_curve);
      if (w < credit) credit = w;
      if (credit > cap) credit = cap;
      left = (src_spent[src] >= limit) ? '0 : limit - src_spent[src];
      if (BudgetW'(credit) > left) credit = left[CapW-1:0];

      src_spent[src] = src_spent[src] + BudgetW'(credit);
      sum = credit_sum + (TotalW + 1)'(credit);
      credit_sum = (sum > TotalMax) ? TotalMax : sum[TotalW-1:0];

      r.credit = credit;
      r.events = src_event_count[src];
      r.spent = src_spent[src];
    end
    r.total = credit_sum;
    r.quality = (credit_sum >= TotalW'(quality_min));
    r.distinct = 6'($countones(low_bit_mask));
    r.min_gap = gap_seen ? min_gap : '0;
    r.max_gap = max_gap;
    pending_credits.push_back(r);
  endtask

  // offers one item and returns at the edge where it is taken, valid still high
  task automatic send_event(input logic [SrcW-1:0] src, input logic [DataW-1:0] data,
                            input logic [StampW-1:0] stamp);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= src;
    s_axis_tdata <= {stamp, data};
    do @(posedge clk_i); while (!s_axis_tready);
    estimate_credit(src, data, stamp);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_credits.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CfgKeyboardCap:      keyboard_cap = value[CapW-1:0];
      CfgDiskCap:          disk_cap = value[CapW-1:0];
      CfgTimerCap:         timer_cap = value[CapW-1:0];
      CfgKeyboardBudget:   keyboard_limit = value;
      CfgDiskBudget:       disk_limit = value;
      CfgTimerBudget:      timer_limit = value;
      CfgQualityThreshold: quality_min = value;
      default: ;
    endcase
  endtask

  task automatic write_all_regs(input logic [CapW-1:0] kb_cap, input logic [CapW-1:0] dk_cap,
                                input logic [CapW-1:0] tm_cap, input logic [BudgetW-1:0] kb_lim,
                                input logic [BudgetW-1:0] dk_lim,
                                input logic [BudgetW-1:0] tm_lim,
                                input logic [BudgetW-1:0] q_min);
    write_reg(CfgKeyboardCap, CfgDataW'(kb_cap));
    write_reg(CfgDiskCap, CfgDataW'(dk_cap));
    write_reg(CfgTimerCap, CfgDataW'(tm_cap));
    write_reg(CfgKeyboardBudget, kb_lim);
    write_reg(CfgDiskBudget, dk_lim);
    write_reg(CfgTimerBudget, tm_lim);
    write_reg(CfgQualityThreshold, q_min);
  endtask

  // intervals are mostly a drifting period with jitter, plus regular, zero,
  // backward and fully random steps
  task automatic send_random_event();
    logic [SrcW-1:0] src;
    logic [StampW-1:0] stamp, step, jitter;
    int k;
    src = ($urandom_range(0, 15) == 0) ? SrcInvalid : SrcW'($urandom_range(0, NumSources - 1));
    k = $urandom_range(0, 24);
    jitter = $urandom() & ((32'd1 << k) - 32'd1);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: step = $urandom_range(0, 1) ? offered_gap + jitter : offered_gap - jitter;
      5: step = offered_gap;
      6: step = $urandom();
      7: step = '0;
      8: step = -jitter;
      default: step = $urandom_range(1, 64);
    endcase
    if (src == SrcInvalid) begin
      stamp = $urandom();
    end else begin
      stamp = offered_stamp + step;
      offered_stamp = stamp;
      offered_gap = step;
    end
    send_event(src, DataW'($urandom()), stamp);
  endtask

  task automatic run_random_events(input int count);
    repeat (count) begin
      send_random_event();
      if (burst_left == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        burst_left = $urandom_range(1, 60);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic apply_random_config();
    logic [CfgDataW-1:0] v;
    for (int i = 0; i <= int'(CfgQualityThreshold); i++) begin
      if (i <= int'(CfgTimerCap)) begin
        case ($urandom_range(0, 3))
          0: v = 16'd0;
          1: v = 16'd32;
          2: v = 16'd63;
          default: v = CfgDataW'($urandom_range(0, 40));
        endcase
      end else begin
        case ($urandom_range(0, 3))
          0: v = 16'd0;
          1: v = 16'hFFFF;
          2: v = CfgDataW'($urandom_range(0, 300));
          default: v = CfgDataW'($urandom());
        endcase
      end
      write_reg(CfgIdxW'(i), v);
    end
    if ($urandom_range(0, 1) == 0) write_reg(CfgUnused, CfgDataW'($urandom()));
  endtask

  // first events after reset: ignored before any interval, an all-ones
  // interval, a zero interval, a regular period and the timer cap of zero
  task automatic test_reset_defaults();
    send_event(SrcInvalid, 16'hFFFF, 32'hFFFF_FFFF);
    send_event(SrcKeyboard, 16'hFFFF, 32'hFFFF_FFFF);
    send_event(SrcDisk, 16'h0000, 32'h0000_0000);
    send_event(SrcTimer, 16'h8001, 32'h0000_0000);
    send_event(SrcKeyboard, 16'h1234, 32'h0001_0000);
    send_event(SrcDisk, 16'h5AA5, 32'h0002_0000);
    send_event(SrcDisk, 16'hA55A, 32'h0003_0005);
    send_event(SrcInvalid, 16'h0000, 32'h0000_0000);
    send_event(SrcKeyboard, 16'h7FFF, 32'h8003_0011);
    wait_idle();
  endtask

  // caps at or above the widest credit, a partly spent budget, a budget lowered
  // below what was already spent, then a keyboard cap of zero
  task automatic test_caps_and_budgets();
    write_all_regs(6'd63, 6'd32, 6'd32, 16'hFFFF, 16'd40, 16'hFFFF, 16'd0);
    write_reg(CfgUnused, 16'hFFFF);
    send_event(SrcKeyboard, 16'h0001, 32'h1234_5678);
    send_event(SrcDisk, 16'h0002, 32'hC000_0000);
    send_event(SrcTimer, 16'h0004, 32'h0000_0001);
    send_event(SrcDisk, 16'h0008, 32'h8765_4321);
    send_event(SrcDisk, 16'h0010, 32'h0F0F_0F0F);
    send_event(SrcKeyboard, 16'h0020, 32'hFEDC_BA98);
    wait_idle();
    write_reg(CfgKeyboardBudget, 16'd3);
    write_reg(CfgQualityThreshold, 16'hFFFF);
    send_event(SrcKeyboard, 16'hC3C3, 32'h3C3C_3C3C);
    send_event(SrcKeyboard, 16'h3C3C, 32'h9999_0000);
    wait_idle();
    write_reg(CfgKeyboardCap, 16'd0);
    send_event(SrcKeyboard, 16'hFFFF, 32'h0000_FFFF);
    wait_idle();
  endtask

  task automatic test_random_default_config();
    write_all_regs(6'd4, 6'd2, 6'd0, 16'd4096, 16'd64, 16'd0, 16'd256);
    run_random_events(300);
    wait_idle();
  endtask

  task automatic test_full_credit();
    write_all_regs(6'd32, 6'd32, 6'd32, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
    run_random_events(250);
    wait_idle();
  endtask

  task automatic test_tight_budgets();
    write_all_regs(6'd63, 6'd0, 6'd7, 16'd150, 16'd0, 16'hFFFF, 16'hFFFF);
    run_random_events(200);
    wait_idle();
  endtask

  task automatic test_random_configs();
    repeat (4) begin
      apply_random_config();
      run_random_events(60);
      wait_idle();
    end
  endtask

  // receiver holds off while the sender keeps offering, then the sender
  // waits for the whole backlog to drain
  task automatic test_backpressure();
    write_all_regs(6'd32, 6'd16, 6'd8, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1000);
    hold_off_reqs++;
    repeat (120) send_random_event();
    wait_idle();
  endtask

  always @(posedge clk_i) begin : check_results
    credit_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_credits.size() == 0) begin
        report_error("result with no event waiting");
      end else begin
        want = pending_credits.pop_front();
        check_field("ignored", 32'(m_axis_tuser), 32'(want.ignored));
        check_field("sample_word", m_axis_tdata[31:0], want.mixed_word);
        check_field("credit_granted", 32'(m_axis_tdata[37:32]), 32'(want.credit));
        check_field("total_credit", 32'(m_axis_tdata[55:38]), 32'(want.total));
        check_field("quality_ok", 32'(m_axis_tdata[56]), 32'(want.quality));
        check_field("source_events", m_axis_tdata[88:57], want.events);
        check_field("source_credit", 32'(m_axis_tdata[104:89]), 32'(want.spent));
        check_field("distinct_low_bits", 32'(m_axis_tdata[110:105]), 32'(want.distinct));
        check_field("min_interval", m_axis_tdata[142:111], want.min_gap);
        check_field("max_interval", m_axis_tdata[174:143], want.max_gap);
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin : drive_ready
    int rx_mode;
    int mode_left;
    int phase;
    rx_mode = 0;
    mode_left = 0;
    phase = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_served != hold_off_reqs) begin
        hold_off_served++;
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else begin
        if (mode_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(8, 80);
        end
        mode_left--;
        phase++;
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= (phase % 5 != 0) && (phase % 7 != 3);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("event_timing_entropy_credit verification failed");
    $finish;
  end

  initial begin
    error_count = 0;
    hold_off_reqs = 0;
    hold_off_served = 0;
    burst_left = 0;
    offered_stamp = '0;
    offered_gap = 32'd100;

    keyboard_cap = 6'd4;
    disk_cap = 6'd2;
    timer_cap = 6'd0;
    keyboard_limit = 16'd4096;
    disk_limit = 16'd64;
    timer_limit = 16'd0;
    quality_min = 16'd256;
    prev_stamp = '0;
    prev_gap = '0;
    prev_gap_delta = '0;
    for (int i = 0; i < NumSources; i++) begin
      src_event_count[i] = '0;
      src_spent[i] = '0;
    end
    credit_sum = '0;
    low_bit_mask = '0;
    min_gap = '1;
    max_gap = '0;
    gap_seen = 1'b0;

    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_caps_and_budgets();
    test_random_default_config();
    test_full_credit();
    test_tight_budgets();
    test_random_configs();
    test_backpressure();

    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("event_timing_entropy_credit verification clean");
    end else begin
      $display("event_timing_entropy_credit verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/etec_pkg.sv
design/etec_ram.sv
design/etec_cfg_regs.sv
design/event_timing_entropy_credit.sv
tb/sv/event_timing_entropy_credit_tb.sv
